FILE: sv/efc_pkg.sv
package efc_pkg;

	localparam int unsigned HdrLen = 18;
	localparam int unsigned CrcEnd = 16;
	localparam int unsigned PosW = 5;
	localparam logic [15:0] CrcPoly = 16'h1021;
	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam int unsigned AgeW = 63;

	typedef enum logic [1:0] {
		VERDICT_OK    = 2'd0,
		VERDICT_SHORT = 2'd1,
		VERDICT_CRC   = 2'd2,
		VERDICT_STALE = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        payload_valid;
		logic        frame_done;
		verdict_t    verdict;
		logic [31:0] frame_counter;
		logic        sequence_gap;
	} result_t;

	// CRC-16/CCITT-FALSE, one byte, MSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: sv/efc_frame_eval.sv
// Per-frame state: byte position, running CRC, header capture, sequence tracking.
// Result logic is combinational on the registered input byte; state commits on step.
module efc_frame_eval (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [7:0]                 data_byte,
	input  logic                       last_byte,
	input  logic signed [63:0]         now_ns,
	input  logic [efc_pkg::AgeW-1:0]   max_age_ns,
	output logic                       has_result,
	output efc_pkg::result_t           result
);

	logic [efc_pkg::PosW-1:0] pos_q;
	logic [15:0]              crc_q;
	logic [31:0]              cnt_q;
	logic [63:0]              ts_q;
	logic [15:0]              hcrc_q;
	logic [31:0]              last_cnt_q;
	logic                     seen_q;

	logic                     is_payload;
	logic [15:0]              crc_next;
	logic [15:0]              hcrc_next;
	logic                     too_short;
	logic                     crc_bad;
	logic [64:0]              age;
	logic                     stale;
	logic                     accepted;
	efc_pkg::verdict_t        verdict;

	assign is_payload = pos_q == efc_pkg::PosW'(efc_pkg::HdrLen);

	always_comb begin
		crc_next = crc_q;
		if (pos_q < efc_pkg::PosW'(efc_pkg::CrcEnd) || is_payload) begin
			crc_next = efc_pkg::crc16_byte(crc_q, data_byte);
		end
		hcrc_next = hcrc_q;
		if (pos_q == efc_pkg::PosW'(efc_pkg::CrcEnd)) begin
			hcrc_next = {hcrc_q[15:8], data_byte};
		end else if (pos_q == efc_pkg::PosW'(efc_pkg::CrcEnd + 1)) begin
			hcrc_next = {data_byte, hcrc_q[7:0]};
		end
	end

	// exact signed difference, one extra bit
	assign age       = {now_ns[63], now_ns} - {ts_q[63], ts_q};
	assign too_short = pos_q < efc_pkg::PosW'(efc_pkg::HdrLen - 1);
	assign crc_bad   = crc_next != hcrc_next;
	assign stale     = (max_age_ns != '0) && !age[64] && (age[63:0] > {1'b0, max_age_ns});

	always_comb begin
		if (too_short) begin
			verdict = efc_pkg::VERDICT_SHORT;
		end else if (crc_bad) begin
			verdict = efc_pkg::VERDICT_CRC;
		end else if (stale) begin
			verdict = efc_pkg::VERDICT_STALE;
		end else begin
			verdict = efc_pkg::VERDICT_OK;
		end
	end

	assign accepted   = last_byte && (verdict == efc_pkg::VERDICT_OK);
	assign has_result = last_byte || is_payload;

	always_comb begin
		result.payload_byte  = is_payload ? data_byte : 8'h00;
		result.payload_valid = is_payload;
		result.frame_done    = last_byte;
		result.verdict       = last_byte ? verdict : efc_pkg::VERDICT_OK;
		result.frame_counter = (last_byte && !too_short) ? cnt_q : 32'h0;
		result.sequence_gap  = accepted && seen_q && (cnt_q != last_cnt_q + 32'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			crc_q      <= efc_pkg::CrcInit;
			cnt_q      <= '0;
			ts_q       <= '0;
			hcrc_q     <= '0;
			last_cnt_q <= '0;
			seen_q     <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				pos_q  <= '0;
				crc_q  <= efc_pkg::CrcInit;
				cnt_q  <= '0;
				ts_q   <= '0;
				hcrc_q <= '0;
				if (accepted) begin
					last_cnt_q <= cnt_q;
					seen_q     <= 1'b1;
				end
			end else begin
				if (!is_payload) begin
					pos_q <= pos_q + 1'b1;
				end
				crc_q  <= crc_next;
				hcrc_q <= hcrc_next;
				if (pos_q >= 5'd4 && pos_q < 5'd8) begin
					cnt_q[{pos_q[1:0], 3'b000} +: 8] <= data_byte;
				end
				if (pos_q >= 5'd8 && pos_q < efc_pkg::PosW'(efc_pkg::CrcEnd)) begin
					ts_q[{pos_q[2:0], 3'b000} +: 8] <= data_byte;
				end
			end
		end
	end

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= efc_pkg::PosW'(efc_pkg::HdrLen))
		else $error("byte position past header length");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_byte |=> pos_q == '0 && crc_q == efc_pkg::CrcInit)
		else $error("frame state not cleared after last byte");

	a_seen_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(seen_q) |-> $past(step && last_byte))
		else $error("sequence state set outside a frame end");

endmodule

FILE: sv/e2e_frame_checker.sv
// End-to-end frame checker. Frames arrive one byte per request on the s_axis side,
// tlast on the final byte, and the current time in the upper tdata bits. Each frame
// opens with an 18-byte little-endian header: bytes 0..3 identifiers, 4..7 counter,
// 8..15 signed timestamp (ns), 16..17 stored CRC. CRC-16/CCITT-FALSE covers bytes
// 0..15 and the payload. Payload bytes are forwarded as they arrive (tuser=1); the
// last byte produces the verdict (tlast=1): ok, header too short, CRC mismatch, or
// stale when max age is nonzero and now - timestamp exceeds it. Rejected payload is
// not erased, so discard by verdict. Header bytes other than the last give no output.
// Throughput is one byte per clock unless the output stalls: an input register feeds
// a single level of CRC, header capture and verdict logic into an output register;
// the age check (65-bit subtract and compare) and the byte-wide CRC update set the
// cycle. Two register stages: m_axis_tvalid rises after the input and then the output
// register, unless a stalled result still holds it. Write max_age_ns only while idle.
module e2e_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [62:0] cfg_wr_data,     // max_age_ns
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,    // [7:0] data_byte, [71:8] now_ns
	input  logic        s_axis_tlast,    // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,    // [7:0] payload_byte, [9:8] verdict,
	                                     // [41:10] frame_counter, [42] sequence_gap
	output logic        m_axis_tuser,    // payload_valid
	output logic        m_axis_tlast     // frame_done
);

	logic [efc_pkg::AgeW-1:0] max_age_q;

	// input stage
	logic                     valid_s1;
	logic [7:0]               byte_s1;
	logic                     last_s1;
	logic signed [63:0]       now_s1;

	// output stage
	logic                     valid_s2;
	efc_pkg::result_t         res_s2;

	logic                     has_result;
	efc_pkg::result_t         result;
	logic                     out_free;
	logic                     go_s1;
	logic                     in_fire;

	// a header byte with no verdict moves on even when the output is blocked
	assign out_free      = !valid_s2 || m_axis_tready;
	assign go_s1         = valid_s1 && (!has_result || out_free);
	assign s_axis_tready = !valid_s1 || go_s1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= '0;
		end else if (cfg_wr_en) begin
			max_age_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= s_axis_tdata[7:0];
			last_s1 <= s_axis_tlast;
			now_s1  <= s_axis_tdata[71:8];
		end
	end

	efc_frame_eval u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (go_s1),
		.data_byte  (byte_s1),
		.last_byte  (last_s1),
		.now_ns     (now_s1),
		.max_age_ns (max_age_q),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= go_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && go_s1 && has_result) begin
			res_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'b00000, res_s2.sequence_gap, res_s2.frame_counter,
	                        res_s2.verdict, res_s2.payload_byte};
	assign m_axis_tuser  = res_s2.payload_valid;
	assign m_axis_tlast  = res_s2.frame_done;

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
		else $error("payload byte set without payload flag");

	a_verdict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[42:8] == '0)
		else $error("verdict fields set outside frame end");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled with empty input stage");

	a_gap_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[42] |->
			m_axis_tlast && m_axis_tdata[9:8] == efc_pkg::VERDICT_OK)
		else $error("sequence gap on a non-accepted frame");

endmodule
